// ===== hdl/adds_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adds_pkg: shared types and constants for the dust density smoother
// Controller states, command and status bundles, and the fixed field widths.
// ----------------------------------------------------------------------------
package adds_pkg;

    localparam int W_SAMPLE  = 10;
    localparam int W_MV      = 20;
    localparam int W_SUM_OUT = 13;
    localparam int W_DUST    = 11;
    localparam int W_CENTI   = 18;

    // quotient width, enough for the saturation point
    localparam int W_Q       = 11;
    // fraction bits of the millivolts-per-count scale
    localparam int Q_FRAC    = 16;

    localparam logic [W_MV-1:0]           MV_RESET  = 20'd320000;
    localparam logic [W_Q-1:0]            Q_OFFSET  = 11'd100;
    localparam logic [W_Q-1:0]            Q_SAT     = 11'd1124;
    localparam logic signed [W_DUST-1:0]  DUST_MAX  = 11'sd1023;
    localparam logic signed [W_DUST-1:0]  DUST_OFS  = 11'sd100;
    localparam logic signed [W_CENTI-1:0] K_CUR     = 18'sd5;
    localparam logic signed [W_CENTI-1:0] K_PREV    = 18'sd95;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_MUL,
        ST_SCALE,
        ST_RECIP,
        ST_FIX,
        ST_ADJ,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic accept;
        logic update;
        logic mul;
        logic scale;
        logic recip;
        logic fix;
        logic adj;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// ===== hdl/adds_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adds_ctrl: sequencer for the dust density smoother
// Steps one sample through ring update, scaling, division and output load.
// ----------------------------------------------------------------------------
module adds_ctrl
    import adds_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    output logic  o_in_stall,
    input  t_sts  i_sts,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_SCALE;
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = ST_RECIP;
            end
            ST_RECIP: begin
                o_cmd.recip = 1'b1;
                n_state     = ST_FIX;
            end
            ST_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = ST_ADJ;
            end
            ST_ADJ: begin
                o_cmd.adj = 1'b1;
                n_state   = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/adds_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adds_datapath: sample ring, running sum, scaling and density conversion
// Holds the config register, the ring memory, a reciprocal-multiply divider
// with remainder correction and the output register.
// ----------------------------------------------------------------------------
module adds_datapath
    import adds_pkg::*;
#(
    parameter int WINDOW = 8
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  t_cmd                       i_cmd,
    output t_sts                       o_sts,
    input  wire                        i_cfg_valid,
    input  wire  [W_MV-1:0]            i_cfg_data,
    input  wire  [W_SAMPLE-1:0]        i_adc_sample,
    output logic                       o_out_valid,
    input  wire                        i_out_stall,
    output logic [W_SUM_OUT-1:0]       o_window_sum,
    output logic signed [W_DUST-1:0]   o_dust_ug,
    output logic signed [W_CENTI-1:0]  o_smoothed_centi
);

    localparam int PTR_W   = $clog2(WINDOW);
    localparam int SUM_W   = $clog2(WINDOW * 1023 + 1);
    localparam int PROD_W  = SUM_W + W_MV;
    localparam int NUM_W   = PROD_W + 5;
    localparam int XS_W    = NUM_W - Q_FRAC;
    localparam int DIVR    = 100 * WINDOW;
    localparam int SAT_LIM = int'(Q_SAT) * DIVR;
    localparam int LIM_W   = $clog2(SAT_LIM);
    localparam int RECIP   = (1 << LIM_W) / DIVR;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int QP_W    = LIM_W + RECIP_W;

    logic [W_MV-1:0]      r_mv;
    logic [W_SAMPLE-1:0]  r_ring [WINDOW];
    logic [W_SAMPLE-1:0]  r_sample;
    logic [W_SAMPLE-1:0]  r_old;
    logic [PTR_W-1:0]     r_ptr;
    logic                 r_full;
    logic [SUM_W-1:0]     r_sum;
    logic [PROD_W-1:0]    r_prod;
    logic [LIM_W-1:0]     r_x;
    logic                 r_sat;
    logic                 r_sticky;
    logic [W_Q-1:0]       r_q;
    logic [LIM_W-1:0]     r_rem;
    logic                 r_inexact;
    logic signed [W_DUST-1:0] r_prev;

    logic [NUM_W-1:0]         n_num;
    logic                     n_sat;
    logic [SUM_W-1:0]         n_old;
    logic [QP_W-1:0]          n_qprod;
    logic [LIM_W-1:0]         n_qd;
    logic signed [W_DUST-1:0] n_dust;
    logic signed [W_CENTI-1:0] n_centi;
    logic [NUM_W-1:0]         prod_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= MV_RESET;
        end else if (i_cfg_valid) begin
            r_mv <= i_cfg_data;
        end
    end

    // ring memory: not reset; until the first wrap the old entry counts as zero in the running sum
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_old <= r_ring[r_ptr];
        end
        if (i_cmd.update) begin
            r_ring[r_ptr] <= r_sample;
        end
    end

    // floor(17*sum*M / (DIVR*2^16)): drop the Q16 fraction into a sticky bit,
    // then estimate x/DIVR by reciprocal multiply (low by at most one)
    always_comb begin
        n_old    = r_full ? SUM_W'(r_old) : '0;
        prod_ext = NUM_W'(r_prod);
        n_num    = (prod_ext << 4) + prod_ext;
        n_sat    = n_num[NUM_W-1:Q_FRAC] >= XS_W'(SAT_LIM);
        n_qprod  = QP_W'(r_x) * QP_W'(RECIP);
        n_qd     = LIM_W'(r_q) * LIM_W'(DIVR);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_full <= 1'b0;
            r_sum  <= '0;
        end else if (i_cmd.update) begin
            r_sum <= r_sum - n_old + SUM_W'(r_sample);
            if (r_ptr == PTR_W'(WINDOW - 1)) begin
                r_ptr  <= '0;
                r_full <= 1'b1;
            end else begin
                r_ptr <= r_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_adc_sample;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_sum) * PROD_W'(r_mv);
        end
        if (i_cmd.scale) begin
            r_x      <= LIM_W'(n_num[NUM_W-1:Q_FRAC]);
            r_sat    <= n_sat;
            r_sticky <= |n_num[Q_FRAC-1:0];
        end
        if (i_cmd.fix) begin
            r_rem <= r_x - n_qd;
        end
        if (i_cmd.recip) begin
            r_q <= W_Q'(n_qprod[QP_W-1:LIM_W]);
        end else if (i_cmd.adj) begin
            if (r_rem >= LIM_W'(DIVR)) begin
                r_q <= r_q + 1'b1;
            end
        end
        if (i_cmd.adj) begin
            r_inexact <= r_sticky || ((r_rem != '0) && (r_rem != LIM_W'(DIVR)));
        end
    end

    // truncate toward zero: below the offset a nonzero remainder rounds up
    always_comb begin
        if (r_sat) begin
            n_dust = DUST_MAX;
        end else if (r_q >= Q_OFFSET) begin
            n_dust = $signed(W_DUST'(r_q - Q_OFFSET));
        end else begin
            n_dust = $signed(W_DUST'(r_q)) - DUST_OFS
                   + (r_inexact ? 11'sd1 : 11'sd0);
        end
        n_centi = W_CENTI'(n_dust) * K_CUR + W_CENTI'(r_prev) * K_PREV;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
            r_prev      <= '0;
        end else begin
            if (i_cmd.finish) begin
                o_out_valid <= 1'b1;
                r_prev      <= n_dust;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_window_sum     <= W_SUM_OUT'(r_sum);
            o_dust_ug        <= n_dust;
            o_smoothed_centi <= n_centi;
        end
    end

    assign o_sts.out_free = !o_out_valid || !i_out_stall;

endmodule
`default_nettype wire

// ===== hdl/adc_dust_density_smoother.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adc_dust_density_smoother: windowed ADC average to dust density
// Input channel: i_in_valid / o_in_stall with i_adc_sample; a transaction
// completes on a clock edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall with o_window_sum, o_dust_ug and
// o_smoothed_centi; the result holds while i_out_stall is high.
// Config channel: i_cfg_valid / o_cfg_ready with i_cfg_data, the Q16
// millivolts-per-count scale; o_cfg_ready is always high. Write only when
// the block is idle.
// Each sample is stepped by the sequencer through ring update, scale multiply,
// Q16 shift, reciprocal multiply, remainder, quotient correction and output
// load, one step per cycle except that output load waits for a free output
// register; a new sample is taken only after output load.
// A finished result waits in the output register while the next sample is
// taken; if it is still stalled when the next result is ready, the
// sequencer holds and o_in_stall stays high.
// Reset (synchronous, active low) clears the window, the running sum and the
// previous density, and restores the scale to 320000.
// ----------------------------------------------------------------------------
module adc_dust_density_smoother
    import adds_pkg::*;
#(
    parameter int WINDOW = 8
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    output logic                       o_in_stall,
    input  wire  [W_SAMPLE-1:0]        i_adc_sample,
    output logic                       o_out_valid,
    input  wire                        i_out_stall,
    output logic [W_SUM_OUT-1:0]       o_window_sum,
    output logic signed [W_DUST-1:0]   o_dust_ug,
    output logic signed [W_CENTI-1:0]  o_smoothed_centi,
    input  wire                        i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire  [W_MV-1:0]            i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    adds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    adds_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .i_adc_sample     (i_adc_sample),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_window_sum     (o_window_sum),
        .o_dust_ug        (o_dust_ug),
        .o_smoothed_centi (o_smoothed_centi)
    );

endmodule
`default_nettype wire

// ===== hdl/adds_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adds_checker: port-level checks for the dust density smoother
// Watches the top-level handshakes and result range over time.
// ----------------------------------------------------------------------------
module adds_checker
    import adds_pkg::*;
(
    input wire                       i_clk,
    input wire                       i_rst_n,
    input wire                       i_in_valid,
    input wire                       o_in_stall,
    input wire [W_SAMPLE-1:0]        i_adc_sample,
    input wire                       o_out_valid,
    input wire                       i_out_stall,
    input wire [W_SUM_OUT-1:0]       o_window_sum,
    input wire signed [W_DUST-1:0]   o_dust_ug,
    input wire signed [W_CENTI-1:0]  o_smoothed_centi
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second sample taken while one is in flight");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=> i_in_valid && $stable(i_adc_sample))
        else $error("stalled sample changed");

    a_dust_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_dust_ug >= -11'sd100) && (o_dust_ug <= 11'sd1023))
        else $error("dust density out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            o_out_valid && $stable(o_window_sum) && $stable(o_dust_ug)
            && $stable(o_smoothed_centi))
        else $error("stalled result changed");

endmodule

bind adc_dust_density_smoother adds_checker u_adds_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .i_adc_sample     (i_adc_sample),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_window_sum     (o_window_sum),
    .o_dust_ug        (o_dust_ug),
    .o_smoothed_centi (o_smoothed_centi)
);
`default_nettype wire
